// File: sv/separable_box_blur_assert.svh
// Assertion helpers for the box blur block
`ifndef SEPARABLE_BOX_BLUR_ASSERT_SVH
`define SEPARABLE_BOX_BLUR_ASSERT_SVH

// same-cycle implication
`define SBB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sbb_pkg.sv
package sbb_pkg;

  localparam int CHAN_W    = 16;
  localparam int NUM_CH    = 3;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int RAD_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic [CFG_W-1:0] RST_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd480;
  localparam logic [RAD_W-1:0] RST_RADIUS = 4'd2;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_RM_INIT,
    S_RM_RD,
    S_RM_WAIT,
    S_RM_GO,
    S_RM_DIV,
    S_CHECK,
    S_EM_INIT,
    S_EM_RD,
    S_EM_WAIT,
    S_EM_GO,
    S_EM_DIV,
    S_EM_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic raw_we;
    logic raw_rd;
    logic line_rd;
    logic line_we;
    logic acc_clr;
    logic div_start;
    logic out_load;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

// File: sv/sbb_ifs.sv
interface sbb_in_if;
  logic           valid;
  logic           ready;
  logic           action;
  sbb_pkg::chan_t in_red;
  sbb_pkg::chan_t in_green;
  sbb_pkg::chan_t in_blue;
  modport source(output valid, action, in_red, in_green, in_blue, input ready);
  modport sink(input valid, action, in_red, in_green, in_blue, output ready);
endinterface

interface sbb_out_if;
  logic           valid;
  logic           ready;
  sbb_pkg::chan_t out_red;
  sbb_pkg::chan_t out_green;
  sbb_pkg::chan_t out_blue;
  logic           frame_last;
  modport source(output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink(input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

// File: sv/separable_box_blur.sv
// Flow: one item at a time; in_ready is high only in idle, so a push that forms n row means
//   and an output, which also waits out output stalls, must finish before the next item is
//   taken. Windows are clipped at frame edges (<= 2r+1); sums are SW = 16 + clog2(2*MAX_RADIUS+2) bits.
// Paced by the shared serial divider (one quotient bit a cycle) and the one-port sweeps.
// Timing: a result is ready the cycle after its item's last state; r rows plus r pixels lag.
// Reset: synchronous active-low; counters clear, registers go to 640/480/2; stores uncleared.
module separable_box_blur #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int MAX_RADIUS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbb_pkg::CFG_W-1:0]     cfg_data,
  sbb_in_if.sink                        in_s,
  sbb_out_if.source                     out_s
);

  `include "separable_box_blur_assert.svh"

  localparam int WB = $clog2(MAX_WIDTH);
  localparam int RB = $clog2(2 * MAX_RADIUS + 2);

  sbb_pkg::cmd_t                        cmd;
  sbb_pkg::status_t                     status;
  logic [RB-1:0]                        raw_addr;
  logic [RB+WB-1:0]                     line_addr;
  logic [RB-1:0]                        cnt;
  sbb_pkg::chan_t [sbb_pkg::NUM_CH-1:0] in_pix;
  sbb_pkg::chan_t [sbb_pkg::NUM_CH-1:0] out_pix;

  assign in_pix = {in_s.in_blue, in_s.in_green, in_s.in_red};
  assign out_s.out_red   = out_pix[0];
  assign out_s.out_green = out_pix[1];
  assign out_s.out_blue  = out_pix[2];

  sbb_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_s.valid),
    .in_action(in_s.action),
    .in_ready (in_s.ready),
    .status   (status),
    .cmd      (cmd),
    .raw_addr (raw_addr),
    .line_addr(line_addr),
    .cnt      (cnt)
  );

  sbb_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .raw_addr   (raw_addr),
    .line_addr  (line_addr),
    .cnt        (cnt),
    .in_pix     (in_pix),
    .out_ready  (out_s.ready),
    .out_valid_r(out_s.valid),
    .out_pix_r  (out_pix),
    .out_last_r (out_s.frame_last)
  );

  `SBB_ASSERT_IMP(a_no_overwrite, cmd.out_load, !status.out_busy, "result overwritten before transfer")
  `SBB_ASSERT_NXT(a_busy_after_accept, cmd.load_in, !in_s.ready, "ready right after an accept")
  `SBB_ASSERT_NXT(a_div_not_instant, cmd.div_start, !status.div_done, "divider done too early")
  `SBB_ASSERT_IMP(a_line_one_op, cmd.line_we, !cmd.line_rd && !cmd.raw_rd, "store port conflict")

endmodule

// File: sv/sbb_ram.sv
module sbb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

// File: sv/sbb_div.sv
module sbb_div #(
  parameter int NW = 21,
  parameter int DW = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [sbb_pkg::NUM_CH-1:0][NW-1:0] dividend,
  input  logic [DW-1:0]                     divisor,
  output logic                              done_r,
  output logic [sbb_pkg::NUM_CH-1:0][NW-1:0] n_r
);

  localparam int CW = $clog2(NW + 1);

  logic                              busy_r;
  logic [CW-1:0]                     cnt_r;
  logic [DW-1:0]                     d_r;
  logic [sbb_pkg::NUM_CH-1:0][DW-1:0] rem_r;
  logic [sbb_pkg::NUM_CH-1:0][DW-1:0] rem_nxt;
  logic [sbb_pkg::NUM_CH-1:0][NW-1:0] n_nxt;
  logic [sbb_pkg::NUM_CH-1:0][DW:0]   t;

  always_comb begin
    for (int ch = 0; ch < sbb_pkg::NUM_CH; ch++) begin
      t[ch] = {rem_r[ch], n_r[ch][NW-1]};
      if (t[ch] >= {1'b0, d_r}) begin
        rem_nxt[ch] = DW'(t[ch] - {1'b0, d_r});
        n_nxt[ch]   = {n_r[ch][NW-2:0], 1'b1};
      end else begin
        rem_nxt[ch] = DW'(t[ch]);
        n_nxt[ch]   = {n_r[ch][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      n_r   <= n_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// File: sv/sbb_datapath.sv
module sbb_datapath #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 15,
  localparam int WB = $clog2(MAX_WIDTH),
  localparam int RB = $clog2(2 * MAX_RADIUS + 2)
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sbb_pkg::cmd_t                          cmd,
  output sbb_pkg::status_t                       status,
  input  logic [RB-1:0]                          raw_addr,
  input  logic [RB+WB-1:0]                       line_addr,
  input  logic [RB-1:0]                          cnt,
  input  sbb_pkg::chan_t [sbb_pkg::NUM_CH-1:0]   in_pix,
  input  logic                                   out_ready,
  output logic                                   out_valid_r,
  output sbb_pkg::chan_t [sbb_pkg::NUM_CH-1:0]   out_pix_r,
  output logic                                   out_last_r
);

  localparam int PW = sbb_pkg::NUM_CH * sbb_pkg::CHAN_W;
  localparam int SW = sbb_pkg::CHAN_W + RB;

  sbb_pkg::chan_t [sbb_pkg::NUM_CH-1:0] pix_r;
  logic [PW-1:0]                        raw_rdata;
  logic [PW-1:0]                        line_rdata;
  logic [PW-1:0]                        acc_data;
  logic [PW-1:0]                        line_wdata;
  logic [sbb_pkg::NUM_CH-1:0][SW-1:0]   sum_r;
  logic [sbb_pkg::NUM_CH-1:0][SW-1:0]   quo;
  logic                                 rd_pend_r;
  logic                                 src_line_r;
  logic                                 div_done;

  sbb_ram #(.WIDTH(PW), .DEPTH(2 ** RB)) u_raw (
    .clk    (clk),
    .we     (cmd.raw_we),
    .waddr  (raw_addr),
    .wdata  (pix_r),
    .raddr  (raw_addr),
    .rdata_r(raw_rdata)
  );

  sbb_ram #(.WIDTH(PW), .DEPTH(2 ** (RB + WB))) u_line (
    .clk    (clk),
    .we     (cmd.line_we),
    .waddr  (line_addr),
    .wdata  (line_wdata),
    .raddr  (line_addr),
    .rdata_r(line_rdata)
  );

  sbb_div #(.NW(SW), .DW(RB)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(sum_r),
    .divisor (cnt),
    .done_r  (div_done),
    .n_r     (quo)
  );

  assign acc_data = src_line_r ? line_rdata : raw_rdata;

  always_comb begin
    for (int ch = 0; ch < sbb_pkg::NUM_CH; ch++) begin
      line_wdata[ch*sbb_pkg::CHAN_W +: sbb_pkg::CHAN_W] = quo[ch][sbb_pkg::CHAN_W-1:0];
    end
  end

  assign status.div_done = div_done;
  assign status.out_busy = out_valid_r & ~out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.raw_rd | cmd.line_rd;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_line_r <= cmd.line_rd;
    if (cmd.load_in) begin
      pix_r <= in_pix;
    end
    for (int ch = 0; ch < sbb_pkg::NUM_CH; ch++) begin
      if (cmd.acc_clr) begin
        sum_r[ch] <= '0;
      end else if (rd_pend_r) begin
        sum_r[ch] <= sum_r[ch] + SW'(acc_data[ch*sbb_pkg::CHAN_W +: sbb_pkg::CHAN_W]);
      end
    end
    if (cmd.out_load) begin
      out_last_r <= cmd.out_last;
      for (int ch = 0; ch < sbb_pkg::NUM_CH; ch++) begin
        out_pix_r[ch] <= quo[ch][sbb_pkg::CHAN_W-1:0];
      end
    end
  end

endmodule

// File: sv/sbb_ctrl.sv
module sbb_ctrl #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int MAX_RADIUS = 15,
  localparam int WB = $clog2(MAX_WIDTH),
  localparam int RB = $clog2(2 * MAX_RADIUS + 2)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbb_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  input  logic                            in_action,
  output logic                            in_ready,
  input  sbb_pkg::status_t                status,
  output sbb_pkg::cmd_t                   cmd,
  output logic [RB-1:0]                   raw_addr,
  output logic [RB+WB-1:0]                line_addr,
  output logic [RB-1:0]                   cnt
);

  localparam int HB  = $clog2(MAX_HEIGHT);
  localparam int WVB = $clog2(MAX_WIDTH + 1);
  localparam int HVB = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_RADIUS + 1);
  localparam int PB  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LB  = PB + 2;
  localparam int CW  = LB + 1;
  localparam int IB  = (WB > HB) ? WB : HB;
  localparam int XB  = ((IB > RW) ? IB : RW) + 2;

  sbb_pkg::state_t state_r, state_nxt;
  logic [sbb_pkg::CFG_W-1:0] fw_r, fw_nxt, fh_r, fh_nxt;
  logic [sbb_pkg::RAD_W-1:0] rad_r, rad_nxt;
  logic                      act_r, act_nxt;
  logic                      emit_r, emit_nxt;
  logic [PB-1:0]             in_pos_r, in_pos_nxt, out_pos_r, out_pos_nxt;
  logic [WB-1:0]             in_x_r, in_x_nxt, out_x_r, out_x_nxt;
  logic [HB-1:0]             in_y_r, in_y_nxt, out_y_r, out_y_nxt, row_y_r, row_y_nxt;
  logic [WB-1:0]             xh_r, xh_nxt, xe_r, xe_nxt;
  logic [IB-1:0]             idx_r, idx_nxt, hi_r, hi_nxt;
  logic [RB-1:0]             cnt_r, cnt_nxt;
  logic [PB-1:0]             total_r;
  logic [LB-1:0]             lag_r;

  logic [WVB-1:0] w_c;
  logic [HVB-1:0] h_c;
  logic [RW-1:0]  r_c;
  logic [XB-1:0]  w_e, h_e, r_e, x_e, base, upper, lo, hi;
  logic           cfg_hit;

  always_comb begin
    if (fw_r == '0) begin
      w_c = WVB'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w_c = WVB'(MAX_WIDTH);
    end else begin
      w_c = WVB'(fw_r);
    end
    if (fh_r == '0) begin
      h_c = HVB'(1);
    end else if (32'(fh_r) > MAX_HEIGHT) begin
      h_c = HVB'(MAX_HEIGHT);
    end else begin
      h_c = HVB'(fh_r);
    end
    if (32'(rad_r) > MAX_RADIUS) begin
      r_c = RW'(MAX_RADIUS);
    end else begin
      r_c = RW'(rad_r);
    end
  end

  assign w_e = XB'(w_c);
  assign h_e = XB'(h_c);
  assign r_e = XB'(r_c);
  assign x_e = XB'(in_x_r);
  assign cnt = cnt_r;
  assign cfg_hit = cfg_we && (cfg_index inside {sbb_pkg::REG_WIDTH, sbb_pkg::REG_HEIGHT,
                                                sbb_pkg::REG_RADIUS});

  always_comb begin
    state_nxt   = state_r;
    fw_nxt      = fw_r;
    fh_nxt      = fh_r;
    rad_nxt     = rad_r;
    act_nxt     = act_r;
    emit_nxt    = emit_r;
    in_pos_nxt  = in_pos_r;
    out_pos_nxt = out_pos_r;
    in_x_nxt    = in_x_r;
    in_y_nxt    = in_y_r;
    out_x_nxt   = out_x_r;
    out_y_nxt   = out_y_r;
    row_y_nxt   = row_y_r;
    xh_nxt      = xh_r;
    xe_nxt      = xe_r;
    idx_nxt     = idx_r;
    hi_nxt      = hi_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    in_ready    = 1'b0;
    raw_addr    = RB'(idx_r);
    line_addr   = {RB'(idx_r), out_x_r};
    base        = '0;
    upper       = '0;
    lo          = '0;
    hi          = '0;

    case (state_r)
      sbb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          act_nxt     = in_action;
          state_nxt   = sbb_pkg::S_DECIDE;
        end
      end
      sbb_pkg::S_DECIDE: begin
        if (!act_r) begin
          if (in_pos_r >= total_r) begin
            state_nxt = sbb_pkg::S_IDLE;
          end else begin
            cmd.raw_we = 1'b1;
            raw_addr   = RB'(in_x_r);
            row_y_nxt  = in_y_r;
            emit_nxt   = (CW'(out_pos_r) + CW'(lag_r)) <= CW'(in_pos_r);
            in_pos_nxt = in_pos_r + 1'b1;
            if (x_e == w_e - 1'b1) begin
              in_x_nxt  = '0;
              in_y_nxt  = in_y_r + 1'b1;
              xh_nxt    = (x_e >= r_e) ? WB'(x_e - r_e) : '0;
              xe_nxt    = WB'(w_e - 1'b1);
              state_nxt = sbb_pkg::S_RM_INIT;
            end else begin
              in_x_nxt = in_x_r + 1'b1;
              if (x_e >= r_e) begin
                xh_nxt    = WB'(x_e - r_e);
                xe_nxt    = WB'(x_e - r_e);
                state_nxt = sbb_pkg::S_RM_INIT;
              end else begin
                state_nxt = sbb_pkg::S_CHECK;
              end
            end
          end
        end else if (in_pos_r >= total_r && out_pos_r < total_r) begin
          state_nxt = sbb_pkg::S_EM_INIT;
        end else begin
          state_nxt = sbb_pkg::S_IDLE;
        end
      end
      sbb_pkg::S_RM_INIT: begin
        base        = XB'(xh_r);
        lo          = (base > r_e) ? base - r_e : '0;
        upper       = base + r_e;
        hi          = (upper > w_e - 1'b1) ? w_e - 1'b1 : upper;
        idx_nxt     = IB'(lo);
        hi_nxt      = IB'(hi);
        cnt_nxt     = RB'(hi - lo + 1'b1);
        cmd.acc_clr = 1'b1;
        state_nxt   = sbb_pkg::S_RM_RD;
      end
      sbb_pkg::S_RM_RD: begin
        cmd.raw_rd = 1'b1;
        raw_addr   = RB'(idx_r);
        if (idx_r == hi_r) begin
          state_nxt = sbb_pkg::S_RM_WAIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      sbb_pkg::S_RM_WAIT: begin
        state_nxt = sbb_pkg::S_RM_GO;
      end
      sbb_pkg::S_RM_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = sbb_pkg::S_RM_DIV;
      end
      sbb_pkg::S_RM_DIV: begin
        line_addr = {RB'(row_y_r), xh_r};
        if (status.div_done) begin
          cmd.line_we = 1'b1;
          if (xh_r == xe_r) begin
            state_nxt = sbb_pkg::S_CHECK;
          end else begin
            xh_nxt    = xh_r + 1'b1;
            state_nxt = sbb_pkg::S_RM_INIT;
          end
        end
      end
      sbb_pkg::S_CHECK: begin
        state_nxt = emit_r ? sbb_pkg::S_EM_INIT : sbb_pkg::S_IDLE;
      end
      sbb_pkg::S_EM_INIT: begin
        base        = XB'(out_y_r);
        lo          = (base > r_e) ? base - r_e : '0;
        upper       = base + r_e;
        hi          = (upper > h_e - 1'b1) ? h_e - 1'b1 : upper;
        idx_nxt     = IB'(lo);
        hi_nxt      = IB'(hi);
        cnt_nxt     = RB'(hi - lo + 1'b1);
        cmd.acc_clr = 1'b1;
        state_nxt   = sbb_pkg::S_EM_RD;
      end
      sbb_pkg::S_EM_RD: begin
        cmd.line_rd = 1'b1;
        line_addr   = {RB'(idx_r), out_x_r};
        if (idx_r == hi_r) begin
          state_nxt = sbb_pkg::S_EM_WAIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      sbb_pkg::S_EM_WAIT: begin
        state_nxt = sbb_pkg::S_EM_GO;
      end
      sbb_pkg::S_EM_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = sbb_pkg::S_EM_DIV;
      end
      sbb_pkg::S_EM_DIV: begin
        if (status.div_done) begin
          state_nxt = sbb_pkg::S_EM_OUT;
        end
      end
      sbb_pkg::S_EM_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (out_pos_r == total_r - 1'b1);
          state_nxt    = sbb_pkg::S_IDLE;
          if ((CW'(out_pos_r) + 1'b1) >= CW'(total_r)) begin
            out_pos_nxt = '0;
            out_x_nxt   = '0;
            out_y_nxt   = '0;
            in_pos_nxt  = '0;
            in_x_nxt    = '0;
            in_y_nxt    = '0;
          end else begin
            out_pos_nxt = out_pos_r + 1'b1;
            if (XB'(out_x_r) == w_e - 1'b1) begin
              out_x_nxt = '0;
              out_y_nxt = out_y_r + 1'b1;
            end else begin
              out_x_nxt = out_x_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = sbb_pkg::S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        sbb_pkg::REG_WIDTH:  fw_nxt  = cfg_data;
        sbb_pkg::REG_HEIGHT: fh_nxt  = cfg_data;
        sbb_pkg::REG_RADIUS: rad_nxt = cfg_data[sbb_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
    if (cfg_hit) begin
      in_pos_nxt  = '0;
      out_pos_nxt = '0;
      in_x_nxt    = '0;
      in_y_nxt    = '0;
      out_x_nxt   = '0;
      out_y_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sbb_pkg::S_IDLE;
      fw_r      <= sbb_pkg::RST_WIDTH;
      fh_r      <= sbb_pkg::RST_HEIGHT;
      rad_r     <= sbb_pkg::RST_RADIUS;
      act_r     <= 1'b0;
      emit_r    <= 1'b0;
      in_pos_r  <= '0;
      out_pos_r <= '0;
      in_x_r    <= '0;
      in_y_r    <= '0;
      out_x_r   <= '0;
      out_y_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      fw_r      <= fw_nxt;
      fh_r      <= fh_nxt;
      rad_r     <= rad_nxt;
      act_r     <= act_nxt;
      emit_r    <= emit_nxt;
      in_pos_r  <= in_pos_nxt;
      out_pos_r <= out_pos_nxt;
      in_x_r    <= in_x_nxt;
      in_y_r    <= in_y_nxt;
      out_x_r   <= out_x_nxt;
      out_y_r   <= out_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_y_r <= row_y_nxt;
    xh_r    <= xh_nxt;
    xe_r    <= xe_nxt;
    idx_r   <= idx_nxt;
    hi_r    <= hi_nxt;
    cnt_r   <= cnt_nxt;
    total_r <= PB'(PB'(w_c) * PB'(h_c));
    lag_r   <= LB'(LB'(r_c) * LB'(w_c)) + LB'(r_c);
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [sbb_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam bit ACT_PUSH = 1'b0;
  localparam bit ACT_DRAIN = 1'b1;
  localparam int RING_DEPTH = 32;
  localparam int LINE_DEPTH = 32 * 2048;
  localparam int SETTLE_CYCLES = 4000;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam int ITEM_TARGET = 1150;
  localparam int HOLD_CYCLES = 1500;

  typedef logic [sbb_pkg::CFG_W-1:0] cfg_word_t;

  typedef struct packed {
    sbb_pkg::chan_t r;
    sbb_pkg::chan_t g;
    sbb_pkg::chan_t b;
  } rgb_t;

  typedef struct packed {
    bit   act;
    rgb_t px;
  } item_t;

  typedef struct packed {
    rgb_t px;
    bit   last;
  } blur_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [sbb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sbb_pkg::CFG_W-1:0] cfg_data;

  sbb_in_if in_if ();
  sbb_out_if out_if ();

  separable_box_blur i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_s(in_if), .out_s(out_if)
  );

  item_t pixel_queue[$];
  blur_t blurred_queue[$];
  int errors;
  longint cycles;
  int items_sent;
  int gap;
  int stall;
  int hold_left;
  bit hold_go;
  bit hold_done;
  bit calm;
  bit took;

  // blur state mirror
  logic [11:0] m_width, m_height;
  logic [3:0] m_radius;
  rgb_t row_ring[RING_DEPTH];
  rgb_t mean_lines[LINE_DEPTH];
  int unsigned in_pos, out_pos;

  function automatic int unsigned eff_w();
    return m_width == 0 ? 1 : (m_width > 2048 ? 2048 : m_width);
  endfunction

  function automatic int unsigned eff_h();
    return m_height == 0 ? 1 : (m_height > 2048 ? 2048 : m_height);
  endfunction

  task automatic form_row_mean(input int unsigned yr, xh, w, r);
    int unsigned lo, hi, cnt, sr, sg, sb, slot;
    lo = xh > r ? xh - r : 0;
    hi = (xh + r > w - 1) ? w - 1 : xh + r;
    cnt = hi - lo + 1;
    sr = 0; sg = 0; sb = 0;
    slot = (yr * w + xh) % LINE_DEPTH;
    for (int unsigned x = lo; x <= hi; x++) begin
      sr += row_ring[x % RING_DEPTH].r;
      sg += row_ring[x % RING_DEPTH].g;
      sb += row_ring[x % RING_DEPTH].b;
    end
    mean_lines[slot] = '{r: sbb_pkg::chan_t'(sr / cnt), g: sbb_pkg::chan_t'(sg / cnt),
                         b: sbb_pkg::chan_t'(sb / cnt)};
  endtask

  task automatic emit_blurred(input int unsigned w, h, r);
    int unsigned yo, xo, lo, hi, cnt, sr, sg, sb, slot;
    blur_t e;
    yo = out_pos / w;
    xo = out_pos % w;
    lo = yo > r ? yo - r : 0;
    hi = (yo + r > h - 1) ? h - 1 : yo + r;
    cnt = hi - lo + 1;
    sr = 0; sg = 0; sb = 0;
    for (int unsigned y = lo; y <= hi; y++) begin
      slot = (y * w + xo) % LINE_DEPTH;
      sr += mean_lines[slot].r;
      sg += mean_lines[slot].g;
      sb += mean_lines[slot].b;
    end
    e.px = '{r: sbb_pkg::chan_t'(sr / cnt), g: sbb_pkg::chan_t'(sg / cnt),
             b: sbb_pkg::chan_t'(sb / cnt)};
    e.last = (out_pos == w * h - 1);
    blurred_queue.push_back(e);
    out_pos++;
    if (out_pos >= w * h) begin
      out_pos = 0;
      in_pos = 0;
    end
  endtask

  task automatic predict_blur(input item_t it);
    int unsigned w, h, r, total, lag, p, yi, xi, xs, xe;
    w = eff_w();
    h = eff_h();
    r = m_radius;
    total = w * h;
    lag = r * w + r;
    if (it.act == ACT_PUSH) begin
      if (in_pos >= total) return;
      p = in_pos;
      yi = p / w;
      xi = p % w;
      row_ring[xi % RING_DEPTH] = it.px;
      if (xi == w - 1) begin
        xs = xi >= r ? xi - r : 0;
        for (int unsigned x = xs; x <= w - 1; x++) form_row_mean(yi, x, w, r);
      end else if (xi >= r) begin
        form_row_mean(yi, xi - r, w, r);
      end
      in_pos = p + 1;
      if (out_pos + lag <= p) emit_blurred(w, h, r);
    end else if (in_pos >= total && out_pos < total) begin
      emit_blurred(w, h, r);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** separable_box_blur: FAILED **");
      $finish;
    end
  end

  // transfer into the block
  always @(posedge clk) begin
    took <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      predict_blur('{act: in_if.action,
                     px: '{r: in_if.in_red, g: in_if.in_green, b: in_if.in_blue}});
      items_sent++;
    end
  end

  always @(negedge clk) begin
    item_t it;
    if (rst_n) begin
      if (in_if.valid && !took) begin
        // hold current offer
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_if.valid <= 1'b0;
      end else if (pixel_queue.size() > 0 && !calm && $urandom_range(0, 3) == 0) begin
        gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
        in_if.valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        it = pixel_queue.pop_front();
        in_if.valid <= 1'b1;
        in_if.action <= it.act;
        in_if.in_red <= it.px.r;
        in_if.in_green <= it.px.g;
        in_if.in_blue <= it.px.b;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold, started once
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall <= stall - 1;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // transfer out of the block
  always @(posedge clk) begin
    blur_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (blurred_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output rgb=%h %h %h last=%b",
          out_if.out_red, out_if.out_green, out_if.out_blue, out_if.frame_last);
      end else begin
        e = blurred_queue.pop_front();
        if (out_if.out_red !== e.px.r || out_if.out_green !== e.px.g ||
            out_if.out_blue !== e.px.b || out_if.frame_last !== e.last) begin
          errors++;
          if (errors <= 10) $display("mismatch exp=%h %h %h last=%b got=%h %h %h last=%b",
            e.px.r, e.px.g, e.px.b, e.last, out_if.out_red, out_if.out_green,
            out_if.out_blue, out_if.frame_last);
        end
      end
    end
  end

  function automatic sbb_pkg::chan_t rand_chan();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return sbb_pkg::chan_t'($urandom);
    endcase
  endfunction

  task automatic settle();
    while (!(pixel_queue.size() == 0 && !in_if.valid && blurred_queue.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sbb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sbb_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sbb_pkg::REG_WIDTH: m_width = val;
      sbb_pkg::REG_HEIGHT: m_height = val;
      sbb_pkg::REG_RADIUS: m_radius = val[sbb_pkg::RAD_W-1:0];
      default: return;
    endcase
    in_pos = 0;
    out_pos = 0;
  endtask

  task automatic set_frame(input int w, h, r);
    write_reg(sbb_pkg::REG_WIDTH, cfg_word_t'(w));
    write_reg(sbb_pkg::REG_HEIGHT, cfg_word_t'(h));
    write_reg(sbb_pkg::REG_RADIUS, cfg_word_t'(r));
  endtask

  // queue one frame; a partial frame runs on into the next one queued
  task automatic queue_frame(input bit partial, input bit noisy);
    int unsigned w, h, total, lag, n, drains;
    item_t it;
    w = eff_w();
    h = eff_h();
    total = w * h;
    lag = m_radius * w + m_radius;
    n = partial ? $urandom_range(0, total) : total;
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        pixel_queue.push_back('{act: ACT_DRAIN, px: '{rand_chan(), rand_chan(), rand_chan()}});
      it = '{act: ACT_PUSH, px: '{rand_chan(), rand_chan(), rand_chan()}};
      pixel_queue.push_back(it);
    end
    if (partial) return;
    drains = total > lag ? lag : total;
    if (noisy && drains > 0 && $urandom_range(0, 3) == 0)
      pixel_queue.push_back('{act: ACT_PUSH, px: '{rand_chan(), rand_chan(), rand_chan()}});
    for (int unsigned i = 0; i < drains; i++)
      pixel_queue.push_back('{act: ACT_DRAIN, px: '{rand_chan(), rand_chan(), rand_chan()}});
  endtask

  initial begin
    int w, h, r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = sbb_pkg::REG_WIDTH;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.action = ACT_PUSH;
    in_if.in_red = '0;
    in_if.in_green = '0;
    in_if.in_blue = '0;
    out_if.ready = 1'b0;
    errors = 0;
    cycles = 0;
    items_sent = 0;
    gap = 0;
    stall = 0;
    hold_left = 0;
    hold_go = 1'b0;
    hold_done = 1'b0;
    calm = 1'b0;
    m_width = sbb_pkg::RST_WIDTH;
    m_height = sbb_pkg::RST_HEIGHT;
    m_radius = sbb_pkg::RST_RADIUS;
    in_pos = 0;
    out_pos = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes and clipped windows
    set_frame(3, 2, 1);
    pixel_queue.push_back('{ACT_DRAIN, '{16'hffff, 16'h0000, 16'h8001}});
    for (int i = 0; i < 6; i++)
      pixel_queue.push_back('{ACT_PUSH, i[0] ? {3{16'hffff}} : 48'h0});
    pixel_queue.push_back('{ACT_PUSH, '{16'h1234, 16'h5678, 16'h9abc}});
    repeat (4) pixel_queue.push_back('{ACT_DRAIN, '{16'h0, 16'h0, 16'h0}});
    settle();
    write_reg(REG_NONE, 12'hfff);
    set_frame(0, 0, 0);
    pixel_queue.push_back('{ACT_PUSH, '{16'hffff, 16'h0001, 16'h8000}});
    pixel_queue.push_back('{ACT_DRAIN, '{16'h0, 16'h0, 16'h0}});
    settle();
    set_frame(2, 3, 15);
    queue_frame(1'b0, 1'b0);
    settle();

    // oversized registers, short runs
    set_frame(12'hfff, 1, 15);
    repeat (40)
      pixel_queue.push_back('{act: ACT_PUSH, px: '{rand_chan(), rand_chan(), rand_chan()}});
    settle();
    set_frame(1, 12'hfff, 1);
    repeat (40)
      pixel_queue.push_back('{act: ACT_PUSH, px: '{rand_chan(), rand_chan(), rand_chan()}});
    settle();

    while (items_sent < ITEM_TARGET) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      h = $urandom_range(1, 8);
      r = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 4);
      set_frame(w, h, r);
      calm = ($urandom_range(0, 5) == 0);
      if (items_sent > 400) hold_go = 1'b1;
      repeat ($urandom_range(1, 3)) queue_frame($urandom_range(0, 5) == 0, 1'b1);
      settle();
      calm = 1'b0;
    end

    if (blurred_queue.size() != 0) errors++;
    if (errors == 0) begin
      $display("** separable_box_blur: PASSED **");
    end else begin
      $display("** separable_box_blur: FAILED **");
    end
    $finish;
  end

endmodule
